// ===== src/stl_pkg.sv =====
// Shared types, codes and character classes for the source token lexer.
// No dependencies; the scanner, queue, top level and testbench import this package.
`default_nettype none

package stl_pkg;

	// Token kinds as they appear on the result channel
	typedef enum logic [3:0] {
		K_END     = 4'd0,
		K_NUM     = 4'd1,
		K_INT     = 4'd2,
		K_IF      = 4'd3,
		K_IDENT   = 4'd4,
		K_EQ      = 4'd5,
		K_ASSIGN  = 4'd6,
		K_SEMI    = 4'd7,
		K_PLUS    = 4'd8,
		K_MINUS   = 4'd9,
		K_LPAREN  = 4'd10,
		K_RPAREN  = 4'd11,
		K_LBRACE  = 4'd12,
		K_RBRACE  = 4'd13,
		K_UNKNOWN = 4'd14
	} kind_t;

	// Scanner mode, one-hot
	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_NUM   = 4'b0010,
		M_IDENT = 4'b0100,
		M_EQ    = 4'b1000
	} mode_t;

	// Keyword prefix tracker, one-hot
	typedef enum logic [5:0] {
		KW_EMPTY = 6'b000001,
		KW_I     = 6'b000010,
		KW_IN    = 6'b000100,
		KW_INT   = 6'b001000,
		KW_IF    = 6'b010000,
		KW_NONE  = 6'b100000
	} kw_t;

	localparam logic [15:0] LEN_MAX    = 16'hFFFF;
	localparam int          OUTQ_DEPTH = 4;
	localparam int          OUTQ_AW    = $clog2(OUTQ_DEPTH);

	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_I  = 8'h69;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	typedef struct packed {
		kind_t       token_kind;
		logic [15:0] start_pos;
		logic [15:0] token_length;
		logic [7:0]  unknown_byte;
		logic        last_of_run;
	} result_t;

	// Results of one item handed from scanner to output queue
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0D, 8'h0A};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER);
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_SEMI:   k = K_SEMI;
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			default:   k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic kw_t kw_next(input kw_t kw, input logic [7:0] c);
		kw_t n;
		n = KW_NONE;
		if (kw == KW_I && c == CH_LOW_N) n = KW_IN;
		if (kw == KW_I && c == CH_LOW_F) n = KW_IF;
		if (kw == KW_IN && c == CH_LOW_T) n = KW_INT;
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== src/stl_in_if.sv =====
// Byte channel into the lexer: valid/ready plus one source byte word.
// Depends on nothing.
`default_nettype none

interface stl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== src/stl_out_if.sv =====
// Token channel out of the lexer: valid/ready plus one token word.
// Depends on nothing.
`default_nettype none

interface stl_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] start_pos;
	logic [15:0] token_length;
	logic [7:0]  unknown_byte;
	logic        last_of_run;

	modport source (output valid, output token_kind, output start_pos, output token_length,
		output unknown_byte, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input start_pos, input token_length,
		input unknown_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/stl_scan.sv =====
// Scanner: input register, lexer state and the per-byte token decision.
// Depends on stl_pkg and stl_in_if.
`default_nettype none

module stl_scan
	import stl_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	stl_in_if.sink       byte_in,
	input  wire          room,
	output push_t        push
);

	localparam int PB = POSITION_BITS;
	localparam logic [PB-1:0] POS_MAX = '1;

	logic          item_v_q;
	logic [7:0]    char_s1;
	logic          eoi_s1;
	logic          advance;

	mode_t         mode_q,  mode_d;
	kw_t           kw_q,    kw_d;
	logic [PB-1:0] start_q, start_d;
	logic [PB-1:0] pos_q,   pos_d;
	logic [15:0]   len_q,   len_d;

	logic          fl_v, own_v;
	result_t       fl_r, own_r;
	kind_t         fl_kind, pk;
	logic          flush_sel;

	function automatic logic [15:0] sat_pos(input logic [PB-1:0] v);
		logic [PB+15:0] w;
		w = {16'd0, v};
		return (w > (PB+16)'(65535)) ? LEN_MAX : w[15:0];
	endfunction

	assign advance       = item_v_q && room;
	assign byte_in.ready = !item_v_q || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (byte_in.ready) begin
			item_v_q <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			char_s1 <= byte_in.char_code;
			eoi_s1  <= byte_in.end_of_input;
		end
	end

	// Token that the pending run would give if closed now
	always_comb begin
		case (mode_q)
			M_NUM:   fl_kind = K_NUM;
			M_IDENT: fl_kind = (kw_q == KW_INT) ? K_INT : ((kw_q == KW_IF) ? K_IF : K_IDENT);
			M_EQ:    fl_kind = K_ASSIGN;
			default: fl_kind = K_END;
		endcase
	end

	assign pk = punct_kind(char_s1);

	always_comb begin
		mode_d  = mode_q;
		kw_d    = kw_q;
		start_d = start_q;
		len_d   = len_q;
		pos_d   = (pos_q < POS_MAX) ? pos_q + PB'(1) : pos_q;

		flush_sel = 1'b0;
		own_v     = 1'b0;
		own_r.token_kind   = K_END;
		own_r.start_pos    = sat_pos(pos_q);
		own_r.token_length = 16'd0;
		own_r.unknown_byte = 8'd0;
		own_r.last_of_run  = 1'b1;

		if (eoi_s1) begin
			flush_sel = 1'b1;
			own_v     = 1'b1;
			mode_d    = M_IDLE;
			kw_d      = KW_EMPTY;
			start_d   = '0;
			len_d     = 16'd0;
			pos_d     = '0;
		end else if (mode_q == M_NUM && is_digit(char_s1)) begin
			if (len_q < LEN_MAX) len_d = len_q + 16'd1;
		end else if (mode_q == M_IDENT && (is_letter(char_s1) || is_digit(char_s1))) begin
			if (len_q < LEN_MAX) len_d = len_q + 16'd1;
			kw_d = kw_next(kw_q, char_s1);
		end else if (mode_q == M_EQ && char_s1 == CH_EQUAL) begin
			own_v = 1'b1;
			own_r.token_kind   = K_EQ;
			own_r.start_pos    = sat_pos(start_q);
			own_r.token_length = 16'd2;
			mode_d = M_IDLE;
			len_d  = 16'd0;
		end else begin
			flush_sel = 1'b1;
			mode_d = M_IDLE;
			len_d  = 16'd0;
			kw_d   = KW_EMPTY;
			if (is_space(char_s1)) begin
				// separator only
			end else if (is_digit(char_s1)) begin
				mode_d  = M_NUM;
				start_d = pos_q;
				len_d   = 16'd1;
			end else if (is_letter(char_s1)) begin
				mode_d  = M_IDENT;
				start_d = pos_q;
				len_d   = 16'd1;
				kw_d    = (char_s1 == CH_LOW_I) ? KW_I : KW_NONE;
			end else if (char_s1 == CH_EQUAL) begin
				mode_d  = M_EQ;
				start_d = pos_q;
				len_d   = 16'd1;
			end else begin
				own_v = 1'b1;
				own_r.token_kind   = pk;
				own_r.token_length = 16'd1;
				own_r.unknown_byte = (pk == K_UNKNOWN) ? char_s1 : 8'd0;
			end
		end
	end

	always_comb begin
		fl_v = flush_sel && (mode_q != M_IDLE);
		fl_r.token_kind   = fl_kind;
		fl_r.start_pos    = sat_pos(start_q);
		fl_r.token_length = (mode_q == M_EQ) ? 16'd1 : len_q;
		fl_r.unknown_byte = 8'd0;
		fl_r.last_of_run  = !own_v;
	end

	// Pack the results in order: pending token first, then this byte's own
	always_comb begin
		push.v0 = advance && (fl_v || own_v);
		push.v1 = advance && fl_v && own_v;
		push.r0 = fl_v ? fl_r : own_r;
		push.r1 = own_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			kw_q    <= KW_EMPTY;
			start_q <= '0;
			len_q   <= 16'd0;
			pos_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			kw_q    <= kw_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDLE) |-> (len_q == 16'd0))
		else $error("idle scanner holds a run length");

	a_eq_single: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_EQ) |-> (len_q == 16'd1))
		else $error("pending assign not one byte long");

	a_kw_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(kw_q != KW_EMPTY) |-> (mode_q == M_IDENT))
		else $error("keyword tracker active outside identifier");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eoi_s1) |=> (pos_q == '0 && mode_q == M_IDLE))
		else $error("end of input did not restart the scanner");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && !push.r0.last_of_run && push.r1.last_of_run))
		else $error("two-token word order broken");

endmodule

`default_nettype wire

// ===== src/stl_outq.sv =====
// Output queue: holds tokens until taken, accepts up to two per cycle while two or more slots are free.
// Depends on stl_pkg and stl_out_if.
`default_nettype none

module stl_outq
	import stl_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  push_t      push,
	output logic       room,
	stl_out_if.source  token_out
);

	localparam int CW = OUTQ_AW + 1;

	result_t            entry_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_q, rd_q;
	logic [CW-1:0]      count_q;
	logic               pop;
	logic [CW-1:0]      n_push;
	result_t            head;

	assign room   = count_q <= CW'(OUTQ_DEPTH - 2);
	assign pop    = token_out.valid && token_out.ready;
	assign n_push = CW'(push.v0) + CW'(push.v1);
	assign head   = entry_q[rd_q];

	assign token_out.valid        = count_q != '0;
	assign token_out.token_kind   = head.token_kind;
	assign token_out.start_pos    = head.start_pos;
	assign token_out.token_length = head.token_length;
	assign token_out.unknown_byte = head.unknown_byte;
	assign token_out.last_of_run  = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.v0) entry_q[wr_q] <= push.r0;
		if (push.v1) entry_q[wr_q + OUTQ_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[OUTQ_AW-1:0];
			if (pop) rd_q <= rd_q + OUTQ_AW'(1);
			count_q <= count_q + n_push - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(OUTQ_DEPTH))
		else $error("output queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room)
		else $error("token pushed without room");

	a_v1_needs_v0: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second token pushed without first");

endmodule

`default_nettype wire

// ===== src/source_token_lexer_core.sv =====
// Source token lexer, top level: scanner followed by the output queue.
// Depends on stl_pkg, stl_in_if, stl_out_if, stl_scan and stl_outq.
//
//  channel    dir  word                                   handshake
//  byte_in    in   char_code[8], end_of_input             valid/ready
//  token_out  out  token_kind[4], start_pos[16],          valid/ready
//                  token_length[16], unknown_byte[8], last_of_run
//
// One byte word per cycle is taken while the queue has room; a byte's tokens are written
// from the input register into the queue and leave from its head. A byte gives zero, one
// or two tokens and the token side drains one per cycle, so the queue can fill up.
// The four-entry output queue stalls the input register when fewer than two slots remain.
// arst_n clears the scanner to idle at position 0 and empties the queue.
`default_nettype none

module source_token_lexer_core
	import stl_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	stl_in_if.sink     byte_in,
	stl_out_if.source  token_out
);

	push_t push;
	logic  room;

	stl_scan #(
		.POSITION_BITS (POSITION_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.room    (room),
		.push    (push)
	);

	stl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.token_out (token_out)
	);

endmodule

`default_nettype wire

// ===== tb/source_token_lexer_core_test.sv =====
// Self-checking test of source_token_lexer_core: random and directed source text in,
// every token word compared with a built-in predictor of the scanner.
// Depends on stl_pkg, stl_in_if, stl_out_if and the lexer RTL.
`default_nettype none

module source_token_lexer_core_test
	import stl_pkg::*;
();

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam int         STALL_LIMIT = 5000;
	localparam int         TAIL_CYCLES = 20;

	class token_predictor;
		mode_t       mode;
		kw_t         kw;
		logic [15:0] tok_start;
		logic [15:0] run_len;
		logic [15:0] pos;
		result_t     step_tokens[$];
		result_t     expected_tokens[$];
		int unsigned mismatches;
		int unsigned tokens_checked;

		function new();
			mismatches = 0;
			tokens_checked = 0;
			restart();
		endfunction

		function void restart();
			mode = M_IDLE;
			kw = KW_EMPTY;
			tok_start = '0;
			run_len = '0;
			pos = '0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
		endfunction

		function bit is_num(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_word(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
		endfunction

		function kind_t punct_token(logic [7:0] c);
			case (c)
				CH_SEMI:   return K_SEMI;
				CH_PLUS:   return K_PLUS;
				CH_MINUS:  return K_MINUS;
				CH_LPAREN: return K_LPAREN;
				CH_RPAREN: return K_RPAREN;
				CH_LBRACE: return K_LBRACE;
				CH_RBRACE: return K_RBRACE;
				default:   return K_UNKNOWN;
			endcase
		endfunction

		function kw_t kw_after(kw_t k, logic [7:0] c);
			if (k == KW_I && c == CH_LOW_N) return KW_IN;
			if (k == KW_I && c == CH_LOW_F) return KW_IF;
			if (k == KW_IN && c == CH_LOW_T) return KW_INT;
			return KW_NONE;
		endfunction

		function void emit(kind_t k, logic [15:0] s, logic [15:0] l, logic [7:0] u);
			result_t t;
			t.token_kind = k;
			t.start_pos = s;
			t.token_length = l;
			t.unknown_byte = u;
			t.last_of_run = 1'b0;
			step_tokens.insert(step_tokens.size(), t);
		endfunction

		function void close_pending();
			kind_t k;
			case (mode)
				M_NUM: emit(K_NUM, tok_start, run_len, '0);
				M_IDENT: begin
					if (kw == KW_INT) k = K_INT;
					else if (kw == KW_IF) k = K_IF;
					else k = K_IDENT;
					emit(k, tok_start, run_len, '0);
				end
				M_EQ: emit(K_ASSIGN, tok_start, 16'd1, '0);
				default: ;
			endcase
			mode = M_IDLE;
			run_len = '0;
			kw = KW_EMPTY;
		endfunction

		function void take_byte(logic [7:0] c, logic eoi);
			kind_t   k;
			if (eoi) begin
				close_pending();
				emit(K_END, pos, '0, '0);
				restart();
			end else begin
				if (mode == M_NUM && is_num(c)) begin
					if (run_len != LEN_MAX) run_len++;
				end else if (mode == M_IDENT && (is_word(c) || is_num(c))) begin
					if (run_len != LEN_MAX) run_len++;
					kw = kw_after(kw, c);
				end else if (mode == M_EQ && c == CH_EQUAL) begin
					emit(K_EQ, tok_start, 16'd2, '0);
					mode = M_IDLE;
					run_len = '0;
				end else begin
					close_pending();
					if (!is_blank(c)) begin
						if (is_num(c) || is_word(c) || c == CH_EQUAL) begin
							if (is_num(c)) mode = M_NUM;
							else if (is_word(c)) mode = M_IDENT;
							else mode = M_EQ;
							tok_start = pos;
							run_len = 16'd1;
							if (mode == M_IDENT) kw = (c == CH_LOW_I) ? KW_I : KW_NONE;
						end else begin
							k = punct_token(c);
							emit(k, pos, 16'd1, (k == K_UNKNOWN) ? c : 8'h00);
						end
					end
				end
				if (pos != 16'hFFFF) pos++;
			end
			// flag the final token of this byte word
			if (step_tokens.size() != 0)
				step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
			foreach (step_tokens[i])
				expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
			step_tokens.delete();
		endfunction

		function string show(result_t t);
			return $sformatf("kind=%0d start=%0d len=%0d byte=%02h last=%0b",
				t.token_kind, t.start_pos, t.token_length, t.unknown_byte, t.last_of_run);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH %s", msg);
		endtask

		task check_token(result_t got);
			result_t want;
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("token %0d unexpected: %s", tokens_checked, show(got)));
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want)
					report_mismatch($sformatf("token %0d: got %s, expected %s",
						tokens_checked, show(got), show(want)));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stl_in_if  byte_in ();
	stl_out_if token_out ();

	source_token_lexer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.token_out (token_out)
	);

	token_predictor lexer_model = new();
	int             tx_idle_pct = 8;
	int             rx_idle_pct = 50;
	int unsigned    bytes_sent = 0;
	int unsigned    sources_sent = 0;
	int unsigned    quiet_cycles = 0;
	result_t        seen_token;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		token_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			token_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Note accepted words, check tokens, watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_in.valid && byte_in.ready)
				lexer_model.take_byte(byte_in.char_code, byte_in.end_of_input);
			if (token_out.valid && token_out.ready) begin
				seen_token.token_kind = kind_t'(token_out.token_kind);
				seen_token.start_pos = token_out.start_pos;
				seen_token.token_length = token_out.token_length;
				seen_token.unknown_byte = token_out.unknown_byte;
				seen_token.last_of_run = token_out.last_of_run;
				lexer_model.check_token(seen_token);
			end
			if ((byte_in.valid && byte_in.ready) || (token_out.valid && token_out.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Called and returns at a falling edge; valid stays high for a following word.
	task automatic send_byte(input logic [7:0] c, input logic eoi);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(negedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.char_code <= c;
		byte_in.end_of_input <= eoi;
		do @(posedge clk); while (!byte_in.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// Hold the sender until every predicted token has come out.
	task automatic drain();
		byte_in.valid <= 1'b0;
		while (lexer_model.expected_tokens.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] pick_word_char(input bit lead);
		case ($urandom_range(0, lead ? 2 : 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return CH_UNDER;
			default: return 8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	function automatic logic [7:0] pick_punct();
		case ($urandom_range(0, 6))
			0: return CH_SEMI;
			1: return CH_PLUS;
			2: return CH_MINUS;
			3: return CH_LPAREN;
			4: return CH_RPAREN;
			5: return CH_LBRACE;
			default: return CH_RBRACE;
		endcase
	endfunction

	task automatic send_lexeme();
		int n;
		case ($urandom_range(0, 11))
			0: send_text("int");
			1: send_text("if");
			2: begin
				// keyword prefixes, sometimes stretched into plain identifiers
				case ($urandom_range(0, 3))
					0: send_text("i");
					1: send_text("in");
					2: send_text("int");
					default: send_text("if");
				endcase
				n = $urandom_range(0, 2);
				repeat (n) send_byte(pick_word_char(1'b0), 1'b0);
			end
			3, 4: begin
				send_byte(pick_word_char(1'b1), 1'b0);
				n = $urandom_range(0, 6);
				repeat (n) send_byte(pick_word_char(1'b0), 1'b0);
			end
			5, 6: begin
				n = $urandom_range(1, 5);
				repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
			end
			7: send_byte(CH_EQUAL, 1'b0);
			8: send_text("==");
			9: send_byte(pick_punct(), 1'b0);
			10: begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(pick_blank(), 1'b0);
			end
			default: send_byte(8'($urandom_range(0, 255)), 1'b0);
		endcase
	endtask

	task automatic send_source();
		int unsigned first;
		int unsigned span;
		first = bytes_sent;
		span = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(4, 40);
		while (bytes_sent - first < span) begin
			if ($urandom_range(0, 9) < 6) send_byte(pick_blank(), 1'b0);
			send_lexeme();
		end
		if ($urandom_range(0, 3) == 0) send_byte(pick_blank(), 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		sources_sent++;
	endtask

	initial begin
		bit drained;
		byte_in.valid = 1'b0;
		byte_in.char_code = 8'h00;
		byte_in.end_of_input = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 50 : 0;
			rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 8 : 0;
			drained = 1'b0;
			if (phase == 0) begin
				// keywords, identifiers, numbers, assign/eq, triple equals, punctuators,
				// null and high bytes, trailing whitespace before the end
				send_text("int if _Z9=07===;+-(){}");
				send_byte(8'h00, 1'b0);
				send_byte(8'hFF, 1'b0);
				send_byte(CH_TAB, 1'b0);
				send_byte(8'hA5, 1'b1);
				sources_sent++;
			end
			while (bytes_sent < 280 * (phase + 1)) begin
				send_source();
				if (!drained && bytes_sent > 280 * phase + 140) begin
					drain();
					drained = 1'b1;
				end
			end
			drain();
		end

		byte_in.valid <= 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d bytes in %0d sources: keywords, operators, unknown bytes, stalls",
			bytes_sent, sources_sent);
		$display("compared %0d tokens, %0d mismatches",
			lexer_model.tokens_checked, lexer_model.mismatches);
		if (lexer_model.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/stl_pkg.sv
src/stl_in_if.sv
src/stl_out_if.sv
src/stl_scan.sv
src/stl_outq.sv
src/source_token_lexer_core.sv
tb/source_token_lexer_core_test.sv
